// ===== hw/rtl/ufmc_pkg.sv =====
// Shared types, constants and helpers for the union-find maze carver.
package ufmc_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int DIM_W     = 11;
    localparam int WALL_W    = 4;
    localparam int RANK_W    = 4;
    localparam int DIV_STEPS = CELL_W;

    localparam logic [WALL_W-1:0] WALL_ALL = 4'hF;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam logic [DIM_W-1:0]  CELL_CAP = DIM_W'(MAX_CELLS);

    // Register indexes
    localparam logic [1:0] CFG_NUM_ROWS   = 2'd0;
    localparam logic [1:0] CFG_NUM_COLS   = 2'd1;
    localparam logic [1:0] CFG_START_CELL = 2'd2;
    localparam logic [1:0] CFG_GOAL_CELL  = 2'd3;

    localparam logic OP_PROPOSE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    localparam logic [1:0] OUT_MERGED   = 2'd0;
    localparam logic [1:0] OUT_OFF_EDGE = 2'd1;
    localparam logic [1:0] OUT_JOINED   = 2'd2;
    localparam logic [1:0] OUT_NONE     = 2'd3;

    // Datapath commands, one per cycle
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_DIV,
        CMD_EDGE,
        CMD_CHK,
        CMD_SAVE_A,
        CMD_SAVE_B,
        CMD_MERGE,
        CMD_MERGE2,
        CMD_CODE,
        CMD_START,
        CMD_SAVE_S,
        CMD_SAVE_G,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic in_range;
        logic is_read;
        logic off;
        logic found;
        logic same;
    } status_t;

    function automatic logic [WALL_W-1:0] wall_bit(input logic [1:0] dir);
        return WALL_W'(1) << dir;
    endfunction

endpackage

// ===== hw/rtl/ufmc_ctrl.sv =====
// Sequencer for the maze carver: steps the datapath through one item.
module ufmc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ufmc_pkg::status_t st,
    output ufmc_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);
    import ufmc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_DIV, S_EDGE, S_FRD, S_FCHK, S_SAVE_A,
        S_SAVE_B, S_RANK, S_MERGE, S_MERGE2, S_WRD, S_CODE, S_SAVE_S, S_SAVE_G
    } state_t;

    typedef enum logic [1:0] {PH_A, PH_B, PH_S, PH_G} phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   busy_reg, done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cmd        = CMD_NOP;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DIV;
                end
            end
            S_LOAD:
                state_next = S_DIV;
            S_DIV:
            begin
                cmd = CMD_DIV;
                if (st.div_last)
                    state_next = S_EDGE;
            end
            S_EDGE:
            begin
                cmd = CMD_EDGE;
                if (!st.in_range || st.is_read || st.off)
                    state_next = S_WRD;
                else
                begin
                    phase_next = PH_A;
                    state_next = S_FRD;
                end
            end
            S_FRD:
                state_next = S_FCHK;
            S_FCHK:
            begin
                cmd = CMD_CHK;
                if (!st.found)
                    state_next = S_FRD;
                else
                begin
                    unique case (phase_reg)
                        PH_A: state_next = S_SAVE_A;
                        PH_B: state_next = S_SAVE_B;
                        PH_S: state_next = S_SAVE_S;
                        PH_G: state_next = S_SAVE_G;
                    endcase
                end
            end
            S_SAVE_A:
            begin
                cmd        = CMD_SAVE_A;
                phase_next = PH_B;
                state_next = S_FRD;
            end
            S_SAVE_B:
            begin
                cmd        = CMD_SAVE_B;
                state_next = st.same ? S_WRD : S_RANK;
            end
            S_RANK:
                state_next = S_MERGE;
            S_MERGE:
            begin
                cmd        = CMD_MERGE;
                state_next = S_MERGE2;
            end
            S_MERGE2:
            begin
                cmd        = CMD_MERGE2;
                state_next = S_WRD;
            end
            S_WRD:
                state_next = S_CODE;
            S_CODE:
            begin
                cmd        = CMD_CODE;
                phase_next = PH_S;
                state_next = S_FRD;
            end
            S_SAVE_S:
            begin
                cmd        = CMD_SAVE_S;
                phase_next = PH_G;
                state_next = S_FRD;
            end
            S_SAVE_G:
            begin
                cmd        = CMD_OUT;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // CODE also points the walker at the start cell
        if (state_reg == S_CODE)
            cmd = CMD_CODE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            phase_reg <= PH_A;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result beat while busy");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result beat repeated");

endmodule

// ===== hw/rtl/ufmc_datapath.sv =====
// Wall, parent and rank stores plus the edge, find and merge datapath.
module ufmc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr,
    input  logic [1:0]                      cfg_addr,
    input  logic [ufmc_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            operation,
    input  logic [ufmc_pkg::CELL_W-1:0]     cell_index,
    input  logic [1:0]                      direction,
    input  ufmc_pkg::cmd_t                  cmd,
    output ufmc_pkg::status_t               st,
    output logic [1:0]                      outcome,
    output logic [ufmc_pkg::WALL_W-1:0]     wall_code,
    output logic                            ends_connected,
    output logic [ufmc_pkg::DIM_W-1:0]      component_count
);
    import ufmc_pkg::*;

    logic [WALL_W-1:0] wall_mem   [MAX_CELLS];
    logic [CELL_W-1:0] parent_mem [MAX_CELLS];
    logic [RANK_W-1:0] rank_mem   [MAX_CELLS];

    logic [DIM_W-1:0]  rows_reg, cols_reg;
    logic [CELL_W-1:0] start_reg, goal_reg;
    logic [DIM_W-1:0]  merges_reg;
    logic [CELL_W-1:0] clr_idx_reg;

    logic              op_reg;
    logic [1:0]        dir_reg;
    logic [CELL_W-1:0] cell_reg, nb_reg, cur_reg, ra_reg, rb_reg;
    logic [DIM_W-1:0]  cells_reg;
    logic [CELL_W-1:0] rem_reg;
    logic [3:0]        div_cnt_reg;
    logic [1:0]        outc_reg;
    logic [WALL_W-1:0] code_reg;
    logic              in_range_reg;

    logic [CELL_W-1:0] parent_q;
    logic [WALL_W-1:0] wall_qa, wall_qb;
    logic [RANK_W-1:0] rank_qa, rank_qb;

    logic [1:0]        outcome_reg;
    logic [WALL_W-1:0] wall_code_reg;
    logic              conn_out_reg;
    logic [DIM_W-1:0]  comps_reg;

    logic [2*DIM_W-1:0] prod;
    logic [DIM_W-1:0]   cells_next;
    logic [DIM_W-1:0]   div_trial;
    logic               off_now;
    logic [CELL_W-1:0]  nb_now;
    logic [DIM_W:0]     cell_ext, sum_cols;
    logic [DIM_W-1:0]   comps_now;

    assign prod       = rows_reg * cols_reg;
    assign cells_next = (prod > (2*DIM_W)'(CELL_CAP)) ? CELL_CAP : prod[DIM_W-1:0];
    assign div_trial  = {rem_reg, cell_reg[CELL_W-1-div_cnt_reg[$clog2(DIV_STEPS)-1:0]]};
    assign cell_ext   = (DIM_W+1)'(cell_reg);
    assign sum_cols   = cell_ext + (DIM_W+1)'(cols_reg);

    always_comb
    begin
        off_now = 1'b0;
        nb_now  = cell_reg;
        unique case (dir_reg)
            DIR_NORTH:
            begin
                off_now = cell_ext < (DIM_W+1)'(cols_reg);
                nb_now  = CELL_W'(cell_ext - (DIM_W+1)'(cols_reg));
            end
            DIR_EAST:
            begin
                off_now = ((DIM_W'(rem_reg) + DIM_W'(1)) == cols_reg) ||
                          ((cell_ext + 1'b1) >= (DIM_W+1)'(cells_reg));
                nb_now  = cell_reg + 1'b1;
            end
            DIR_SOUTH:
            begin
                off_now = sum_cols >= (DIM_W+1)'(cells_reg);
                nb_now  = CELL_W'(sum_cols);
            end
            DIR_WEST:
            begin
                off_now = (rem_reg == '0);
                nb_now  = cell_reg - 1'b1;
            end
        endcase
    end

    assign comps_now = (cells_reg > merges_reg) ? (cells_reg - merges_reg) : '0;

    assign st.clr_last = (clr_idx_reg == CELL_W'(MAX_CELLS - 1));
    assign st.div_last = (div_cnt_reg == 4'(DIV_STEPS - 1));
    assign st.in_range = (DIM_W'(cell_reg) < cells_reg);
    assign st.is_read  = (op_reg == OP_READ);
    assign st.off      = off_now;
    assign st.found    = (parent_q == cur_reg);
    assign st.same     = (ra_reg == cur_reg);

    // Stores: reads every cycle at the current pointers, registered
    always_ff @(posedge clk)
    begin
        parent_q <= parent_mem[cur_reg];
        wall_qa  <= wall_mem[cell_reg];
        wall_qb  <= wall_mem[nb_reg];
        rank_qa  <= rank_mem[ra_reg];
        rank_qb  <= rank_mem[rb_reg];
        if (cmd == CMD_CLEAR)
        begin
            wall_mem[clr_idx_reg]   <= WALL_ALL;
            parent_mem[clr_idx_reg] <= clr_idx_reg;
            rank_mem[clr_idx_reg]   <= '0;
        end
        else if (cmd == CMD_MERGE)
        begin
            wall_mem[cell_reg] <= wall_qa & ~wall_bit(dir_reg);
            if (rank_qa < rank_qb)
                parent_mem[ra_reg] <= rb_reg;
            else
                parent_mem[rb_reg] <= ra_reg;
            if (rank_qa == rank_qb && rank_qa != RANK_MAX)
                rank_mem[ra_reg] <= rank_qa + 1'b1;
        end
        else if (cmd == CMD_MERGE2)
            wall_mem[nb_reg] <= wall_qb & ~wall_bit(dir_reg + 2'd2);
    end

    // Configuration and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= DIM_W'(32);
            cols_reg    <= DIM_W'(32);
            start_reg   <= '0;
            goal_reg    <= CELL_W'(31);
            merges_reg  <= '0;
            clr_idx_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_addr)
                    CFG_NUM_ROWS:   rows_reg  <= cfg_data;
                    CFG_NUM_COLS:   cols_reg  <= cfg_data;
                    CFG_START_CELL: start_reg <= cfg_data[CELL_W-1:0];
                    CFG_GOAL_CELL:  goal_reg  <= cfg_data[CELL_W-1:0];
                endcase
            end
            if (cmd == CMD_CLEAR)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            if (cmd == CMD_MERGE2)
                merges_reg <= merges_reg + 1'b1;
            if (cmd == CMD_LOAD)
                div_cnt_reg <= '0;
            else if (cmd == CMD_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                op_reg    <= operation;
                cell_reg  <= cell_index;
                dir_reg   <= direction;
                cells_reg <= cells_next;
                rem_reg   <= '0;
            end
            CMD_DIV:
                rem_reg <= (div_trial >= cols_reg) ? CELL_W'(div_trial - cols_reg)
                                                   : CELL_W'(div_trial);
            CMD_EDGE:
            begin
                in_range_reg <= st.in_range;
                nb_reg       <= nb_now;
                cur_reg      <= cell_reg;
                if (!st.in_range || st.is_read)
                    outc_reg <= OUT_NONE;
                else if (off_now)
                    outc_reg <= OUT_OFF_EDGE;
                else
                    outc_reg <= OUT_MERGED;
            end
            CMD_CHK:
                if (!st.found)
                    cur_reg <= parent_q;
            CMD_SAVE_A:
            begin
                ra_reg  <= cur_reg;
                cur_reg <= nb_reg;
            end
            CMD_SAVE_B:
            begin
                rb_reg <= cur_reg;
                if (st.same)
                    outc_reg <= OUT_JOINED;
            end
            CMD_CODE:
            begin
                code_reg <= in_range_reg ? wall_qa : '0;
                cur_reg  <= start_reg;
            end
            CMD_SAVE_S:
            begin
                ra_reg  <= cur_reg;
                cur_reg <= goal_reg;
            end
            CMD_OUT:
            begin
                outcome_reg   <= outc_reg;
                wall_code_reg <= code_reg;
                conn_out_reg  <= (DIM_W'(start_reg) < cells_reg) &&
                                 (DIM_W'(goal_reg) < cells_reg) && (ra_reg == cur_reg);
                comps_reg     <= comps_now;
            end
            default:
            begin
            end
        endcase
    end

    assign outcome         = outcome_reg;
    assign wall_code       = wall_code_reg;
    assign ends_connected  = conn_out_reg;
    assign component_count = comps_reg;

endmodule

// ===== hw/rtl/union_find_maze_carver_core.sv =====
// Top level of the union-find maze carver.
// Carves a grid maze by randomized Kruskal: start with one item (operation,
// cell_index, direction) when busy is low; exactly one result beat follows,
// shown for one cycle with done high, and it cannot be held off. After reset
// the block runs a clearing pass over its stores with busy high;
// configuration writes are taken during it. Before done rises an item runs
// ten restoring steps for the column remainder, one edge test, walks of
// parent chains through the single-read parent store (cell and neighbor
// roots for an in-range, on-grid proposal, then start and goal roots), a
// read and a check per chain entry, and for a merge a rank read and the
// MERGE and MERGE2 writes. Busy drops as done rises, so the next item can
// be taken in the result cycle.
module union_find_maze_carver_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr,
    input  logic [1:0]                      cfg_addr,
    input  logic [ufmc_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic                            operation,
    input  logic [ufmc_pkg::CELL_W-1:0]     cell_index,
    input  logic [1:0]                      direction,
    output logic                            done,
    output logic [1:0]                      outcome,
    output logic [ufmc_pkg::WALL_W-1:0]     wall_code,
    output logic                            ends_connected,
    output logic [ufmc_pkg::DIM_W-1:0]      component_count
);
    import ufmc_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Sequencer: one command per cycle, status back
    ufmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Stores, find walker and result registers
    ufmc_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr          (cfg_wr),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .operation       (operation),
        .cell_index      (cell_index),
        .direction       (direction),
        .cmd             (cmd),
        .st              (st),
        .outcome         (outcome),
        .wall_code       (wall_code),
        .ends_connected  (ends_connected),
        .component_count (component_count)
    );

endmodule

// ===== test/ufmc_checker.sv =====
// Checker for the maze carver: tracks config, predicts each result beat and compares.
module ufmc_checker
    import ufmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr,
    input  logic [1:0]        cfg_addr,
    input  logic [DIM_W-1:0]  cfg_data,
    input  logic              start,
    input  logic              busy,
    input  logic              operation,
    input  logic [CELL_W-1:0] cell_index,
    input  logic [1:0]        direction,
    input  logic              done,
    input  logic [1:0]        outcome,
    input  logic [WALL_W-1:0] wall_code,
    input  logic              ends_connected,
    input  logic [DIM_W-1:0]  component_count,
    output int                fails,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]        outcome;
        logic [WALL_W-1:0] wall;
        logic              conn;
        logic [DIM_W-1:0]  comps;
    } carve_beat_t;

    carve_beat_t expected_beats[$];

    logic [DIM_W-1:0]  rows_q, cols_q;
    logic [CELL_W-1:0] start_q, goal_q;
    logic [WALL_W-1:0] walls[MAX_CELLS];
    int                parent[MAX_CELLS];
    int                rank_q[MAX_CELLS];
    int                merges;

    function automatic int grid_cells();
        int prod;
        prod = int'(rows_q) * int'(cols_q);
        return (prod > MAX_CELLS) ? MAX_CELLS : prod;
    endfunction

    function automatic int find_root(int c);
        int p;
        for (int k = 0; k < MAX_CELLS; k++)
        begin
            p = parent[c];
            if (p == c)
                break;
            c = p;
        end
        return c;
    endfunction

    // Applies one item to the shadow maze and returns the beat it yields.
    function automatic carve_beat_t carve_step(logic op, int cell_id, int dir);
        carve_beat_t r;
        int cells, cols, nb, ra, rb, comps;
        logic off;
        cells = grid_cells();
        cols = int'(cols_q);
        r.wall = '0;
        nb = 0;
        if (cell_id >= cells)
            r.outcome = OUT_NONE;
        else if (op == OP_READ)
        begin
            r.outcome = OUT_NONE;
            r.wall = walls[cell_id];
        end
        else
        begin
            case (dir)
                DIR_NORTH: begin off = cell_id < cols; nb = cell_id - cols; end
                DIR_EAST:  begin off = ((cell_id + 1) % cols == 0) || (cell_id + 1 >= cells);
                                 nb = cell_id + 1; end
                DIR_SOUTH: begin off = cell_id + cols >= cells; nb = cell_id + cols; end
                default:   begin off = (cell_id % cols) == 0; nb = cell_id - 1; end
            endcase
            if (off)
                r.outcome = OUT_OFF_EDGE;
            else
            begin
                ra = find_root(cell_id);
                rb = find_root(nb);
                if (ra == rb)
                    r.outcome = OUT_JOINED;
                else
                begin
                    walls[cell_id] &= ~(4'b1 << dir);
                    walls[nb] &= ~(4'b1 << ((dir + 2) & 3));
                    // union by rank, rank saturating
                    if (rank_q[ra] < rank_q[rb])
                        parent[ra] = rb;
                    else if (rank_q[ra] > rank_q[rb])
                        parent[rb] = ra;
                    else
                    begin
                        parent[rb] = ra;
                        if (rank_q[ra] < 15)
                            rank_q[ra]++;
                    end
                    merges++;
                    r.outcome = OUT_MERGED;
                end
            end
            r.wall = walls[cell_id];
        end
        r.conn = (int'(start_q) < cells) && (int'(goal_q) < cells) &&
                 (find_root(int'(start_q)) == find_root(int'(goal_q)));
        comps = (cells > merges) ? cells - merges : 0;
        if (comps > 2047)
            comps = 2047;
        r.comps = DIM_W'(comps);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        carve_beat_t want;
        if (!rst_n)
        begin
            rows_q = DIM_W'(32);
            cols_q = DIM_W'(32);
            start_q = '0;
            goal_q = CELL_W'(31);
            for (int i = 0; i < MAX_CELLS; i++)
            begin
                walls[i] = WALL_ALL;
                parent[i] = i;
                rank_q[i] = 0;
            end
            merges = 0;
            expected_beats.delete();
            fails = 0;
            pending = 0;
        end
        else
        begin
            // result side first: a beat never belongs to an item taken this edge
            if (done)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fails++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, got %0d", want.outcome, outcome);
                        fails++;
                    end
                    if (wall_code !== want.wall)
                    begin
                        $error("wall_code: expected %0h, got %0h", want.wall, wall_code);
                        fails++;
                    end
                    if (ends_connected !== want.conn)
                    begin
                        $error("ends_connected: expected %0d, got %0d", want.conn,
                               ends_connected);
                        fails++;
                    end
                    if (component_count !== want.comps)
                    begin
                        $error("component_count: expected %0d, got %0d", want.comps,
                               component_count);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                expected_beats.push_back(carve_step(operation, int'(cell_index),
                                                    int'(direction)));
            if (cfg_wr)
            begin
                case (cfg_addr)
                    CFG_NUM_ROWS:   rows_q = cfg_data;
                    CFG_NUM_COLS:   cols_q = cfg_data;
                    CFG_START_CELL: start_q = cfg_data[CELL_W-1:0];
                    default:        goal_q = cfg_data[CELL_W-1:0];
                endcase
            end
            pending = expected_beats.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the maze carver core.
module tb;
    import ufmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr = 1'b0;
    logic [1:0]        cfg_addr = CFG_NUM_ROWS;
    logic [DIM_W-1:0]  cfg_data = '0;
    logic              start = 1'b0;
    logic              busy;
    logic              operation = OP_READ;
    logic [CELL_W-1:0] cell_index = '0;
    logic [1:0]        direction = DIR_NORTH;
    logic              done;
    logic [1:0]        outcome;
    logic [WALL_W-1:0] wall_code;
    logic              ends_connected;
    logic [DIM_W-1:0]  component_count;
    int                fails;
    int                pending;

    // Current grid as the stimulus sees it, for aiming cells in range.
    int cur_cells;
    int gap_pct;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    union_find_maze_carver_core uut (.*);

    ufmc_checker checker_i (.*);

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Quiet the command side until every beat is back, then let trailing work settle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_grid(int rows, int cols, int s_cell, int g_cell);
        int prod;
        cfg_wr <= 1'b1;
        cfg_addr <= CFG_NUM_ROWS;   cfg_data <= DIM_W'(rows);   @(posedge clk);
        cfg_addr <= CFG_NUM_COLS;   cfg_data <= DIM_W'(cols);   @(posedge clk);
        cfg_addr <= CFG_START_CELL; cfg_data <= DIM_W'(s_cell); @(posedge clk);
        cfg_addr <= CFG_GOAL_CELL;  cfg_data <= DIM_W'(g_cell); @(posedge clk);
        cfg_wr <= 1'b0;
        prod = rows * cols;
        cur_cells = (prod > MAX_CELLS) ? MAX_CELLS : prod;
    endtask

    // One command beat; random gap in front of it per the phase's idle rate.
    task automatic send(logic op, int cell_id, logic [1:0] dir);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        cell_index <= CELL_W'(cell_id);
        direction <= dir;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Mostly in-grid proposals so the forest actually grows; some reads and strays.
    task automatic random_item();
        int pick;
        int cell_id;
        pick = $urandom_range(99);
        if (cur_cells == 0 || pick < 8)
            cell_id = $urandom_range(MAX_CELLS - 1);
        else
            cell_id = $urandom_range(cur_cells - 1);
        send((pick >= 8 && pick < 22) ? OP_READ : OP_PROPOSE, cell_id,
             2'($urandom_range(3)));
    endtask

    initial
    begin
        int rows_t[10]  = '{4, 1, 1,    1024, 2047, 0, 8, 2, 5,  32};
        int cols_t[10]  = '{4, 1, 1024, 1,    2047, 5, 3, 2, 7,  32};
        int start_t[10] = '{0, 0, 0,    5,    3,    0, 2, 0, 34, 0};
        int goal_t[10]  = '{15, 0, 1023, 1000, 1023, 0, 23, 3, 0, 31};
        int pct_t[4]    = '{0, 54, 0, 32};
        int per_phase;

        cur_cells = MAX_CELLS;
        gap_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default 32x32 grid, start 0, goal 31.
        send(OP_READ, 0, DIR_NORTH);
        send(OP_READ, 1023, DIR_NORTH);
        send(OP_PROPOSE, 0, DIR_NORTH);     // top edge
        send(OP_PROPOSE, 0, DIR_WEST);      // left edge
        send(OP_PROPOSE, 1023, DIR_SOUTH);  // bottom edge
        send(OP_PROPOSE, 1023, DIR_EAST);   // last cell
        send(OP_PROPOSE, 31, DIR_EAST);     // right column wraps
        send(OP_PROPOSE, 992, DIR_SOUTH);
        send(OP_PROPOSE, 0, DIR_EAST);      // merge
        send(OP_PROPOSE, 1, DIR_WEST);      // already joined
        send(OP_PROPOSE, 32, DIR_NORTH);    // merge
        send(OP_PROPOSE, 1, DIR_SOUTH);     // merge
        send(OP_PROPOSE, 33, DIR_WEST);     // joined through the chain
        send(OP_PROPOSE, 1023, DIR_NORTH);
        send(OP_PROPOSE, 1023, DIR_WEST);
        send(OP_READ, 0, DIR_NORTH);
        send(OP_READ, 1, DIR_NORTH);
        send(OP_READ, 1023, DIR_NORTH);

        per_phase = 155;
        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            set_grid(rows_t[ph], cols_t[ph], start_t[ph], goal_t[ph]);
            gap_pct = pct_t[ph % 4];
            for (int n = 0; n < per_phase; n++)
            begin
                // drain once per phase: let the core run dry mid-stream
                if (n == per_phase / 2)
                    drain();
                random_item();
            end
        end

        drain();
        if (fails == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
